### hdl/dirp_pkg.sv
// shared types and constants of the dictionary index record parser
package dirp_pkg;

   localparam int unsigned SIZE_BYTES          = 4;
   localparam int unsigned NARROW_OFFSET_BYTES = 4;
   localparam int unsigned WIDE_OFFSET_BYTES   = 8;

   localparam int unsigned OFFSET_W = 64;
   localparam int unsigned SIZE_W   = 32;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned META_W   = 4;

   // rsp_tdata: word_char, lower_char, entry_offset, entry_size, records_seen, no_records
   localparam int unsigned RSP_FIELDS_W = 2 * CHAR_W + OFFSET_W + SIZE_W + COUNT_W + 1;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_DELTA   = 8'h20;

   typedef enum logic [1:0] {
      KIND_WORD    = 2'd0,
      KIND_RECORD  = 2'd1,
      KIND_DROPPED = 2'd2,
      KIND_SUMMARY = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [CHAR_W-1:0]     word_char;
      logic [CHAR_W-1:0]     lower_char;
      logic [OFFSET_W-1:0]   entry_offset;
      logic [SIZE_W-1:0]     entry_size;
      logic [COUNT_W-1:0]    records_seen;
      logic                  no_records;
      logic                  run_end;
   } result_type;

endpackage

### hdl/dictionary_index_record_parser.sv
// top level of the dictionary index record parser
// Takes one index byte per cycle on req (tlast marks the final byte of a buffer) and
// parses records of a zero-terminated word, a 4- or 8-byte big-endian offset (csr bit,
// 1 = 8 bytes) and a 4-byte big-endian size. Word bytes come out with a lowercased copy,
// a finished record gives its offset and size, and the final byte gives a dropped-record
// word when a record was cut short (or the completing record) followed by a summary with
// the saturating record count. The parser state updates in the cycle a byte is accepted
// and its results go into a four-entry result queue, so a new byte is taken every cycle
// while the queue has room for two words, and a final byte yields two words.
// The csr bit is to be written only while the block is idle.
module dictionary_index_record_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic                             csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] data_byte
   input  logic                             req_tlast,   // final_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] word_char, [15:8] lower_char, [79:16] entry_offset, [111:80] entry_size,
   // [143:112] records_seen, [144] no_records, rest zero
   output logic [dirp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                       rsp_tuser,   // [1:0] result_kind
   output logic                             rsp_tlast    // run_end
);
   import dirp_pkg::*;

   logic                     wide_offsets_ff;
   logic                     in_meta_ff, in_meta_in;
   logic [META_W-1:0]        meta_count_ff, meta_count_in;
   logic                     record_open_ff, record_open_in;
   logic [OFFSET_W-1:0]      offset_acc_ff, offset_acc_in;
   logic [SIZE_W-1:0]        size_acc_ff, size_acc_in;
   logic [COUNT_W-1:0]       record_total_ff, record_total_in;

   result_type               queue_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   head_ff, head_in;
   logic [QUEUE_PTR_W-1:0]   tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   logic                     req_accept;
   logic                     rsp_accept;
   logic [1:0]               push_count;
   result_type               res0, res1;
   result_type               head_word;
   logic [META_W:0]          off_len;
   logic                     completed;
   logic [CHAR_W-1:0]        data_byte;
   logic                     final_byte;

   assign data_byte  = req_tdata;
   assign final_byte = req_tlast;
   assign req_tready = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign off_len    = wide_offsets_ff ? (META_W+1)'(WIDE_OFFSET_BYTES)
                                       : (META_W+1)'(NARROW_OFFSET_BYTES);

   always_comb begin
      in_meta_in      = in_meta_ff;
      meta_count_in   = meta_count_ff;
      record_open_in  = record_open_ff;
      offset_acc_in   = offset_acc_ff;
      size_acc_in     = size_acc_ff;
      record_total_in = record_total_ff;
      res0            = '0;
      res1            = '0;
      push_count      = 2'd0;
      completed       = 1'b0;
      if (req_accept) begin
         if (!in_meta_ff) begin
            record_open_in = 1'b1;
            if (data_byte == '0) begin
               // terminator, also of an empty word
               in_meta_in    = 1'b1;
               meta_count_in = '0;
               offset_acc_in = '0;
               size_acc_in   = '0;
            end else if (!final_byte) begin
               res0.kind       = KIND_WORD;
               res0.word_char  = data_byte;
               res0.lower_char = (data_byte >= CHAR_UPPER_A && data_byte <= CHAR_UPPER_Z)
                                 ? data_byte + CASE_DELTA : data_byte;
               push_count      = 2'd1;
            end
         end else begin
            if ({1'b0, meta_count_ff} < off_len) begin
               offset_acc_in = {offset_acc_ff[OFFSET_W-CHAR_W-1:0], data_byte};
            end else begin
               size_acc_in = {size_acc_ff[SIZE_W-CHAR_W-1:0], data_byte};
            end
            meta_count_in = meta_count_ff + META_W'(1);
            if ({1'b0, meta_count_in} >= off_len + (META_W+1)'(SIZE_BYTES)) begin
               res0.kind         = KIND_RECORD;
               res0.entry_offset = offset_acc_in;
               res0.entry_size   = size_acc_in;
               push_count        = 2'd1;
               if (record_total_ff != '1) begin
                  record_total_in = record_total_ff + COUNT_W'(1);
               end
               in_meta_in     = 1'b0;
               meta_count_in  = '0;
               record_open_in = 1'b0;
               offset_acc_in  = '0;
               size_acc_in    = '0;
               completed      = 1'b1;
            end
         end
         if (final_byte) begin
            if (!completed && record_open_in) begin
               res0.kind  = KIND_DROPPED;
               push_count = 2'd1;
            end
            // summary goes into the next free slot
            if (push_count == 2'd0) begin
               res0.kind         = KIND_SUMMARY;
               res0.records_seen = record_total_in;
               res0.no_records   = record_total_in == '0;
               push_count        = 2'd1;
            end else begin
               res1.kind         = KIND_SUMMARY;
               res1.records_seen = record_total_in;
               res1.no_records   = record_total_in == '0;
               push_count        = 2'd2;
            end
            in_meta_in      = 1'b0;
            meta_count_in   = '0;
            record_open_in  = 1'b0;
            offset_acc_in   = '0;
            size_acc_in     = '0;
            record_total_in = '0;
         end
         case (push_count)
            2'd1:    res0.run_end = 1'b1;
            2'd2:    res1.run_end = 1'b1;
            default: ;
         endcase
      end
   end

   always_comb begin
      head_in  = rsp_accept ? head_ff + QUEUE_PTR_W'(1) : head_ff;
      tail_in  = tail_ff + QUEUE_PTR_W'(push_count);
      count_in = count_ff + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_offsets_ff <= 1'b0;
         in_meta_ff      <= 1'b0;
         meta_count_ff   <= '0;
         record_open_ff  <= 1'b0;
         offset_acc_ff   <= '0;
         size_acc_ff     <= '0;
         record_total_ff <= '0;
         head_ff         <= '0;
         tail_ff         <= '0;
         count_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            wide_offsets_ff <= csr_wr_data;
         end
         in_meta_ff      <= in_meta_in;
         meta_count_ff   <= meta_count_in;
         record_open_ff  <= record_open_in;
         offset_acc_ff   <= offset_acc_in;
         size_acc_ff     <= size_acc_in;
         record_total_ff <= record_total_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_mem[tail_ff] <= res0;
      end
      if (push_count == 2'd2) begin
         queue_mem[tail_ff + QUEUE_PTR_W'(1)] <= res1;
      end
   end

   assign head_word = queue_mem[head_ff];
   assign rsp_tuser = head_word.kind;
   assign rsp_tlast = head_word.run_end;
   assign rsp_tdata = {(RSP_DATA_W - RSP_FIELDS_W)'(0),
                       head_word.no_records,
                       head_word.records_seen,
                       head_word.entry_size,
                       head_word.entry_offset,
                       head_word.lower_char,
                       head_word.word_char};

endmodule

### verif/tb_dictionary_index_record_parser.sv
// self-checking testbench of the dictionary index record parser: directed table, then random buffers
module tb_dictionary_index_record_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import dirp_pkg::*;

   localparam int DRAIN_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 550;
   localparam int RUN_LIMIT_NS  = 2_000_000;

   typedef enum {CFG_KEEP, CFG_NARROW, CFG_WIDE} width_action_type;

   typedef struct {
      logic [7:0]       data;
      bit               last;
      width_action_type action;
      int               n_typed;
      result_type       typed0;
      result_type       typed1;
   } stim_row_type;

   localparam result_type NO_RESULT = '0;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic                  csr_wr_data = 1'b0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = 8'h00;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   // parser state as the testbench sees it
   bit                    wide_model;
   bit                    reading_meta;
   logic [META_W-1:0]     meta_taken;
   bit                    record_started;
   logic [OFFSET_W-1:0]   offset_built;
   logic [SIZE_W-1:0]     size_built;
   logic [COUNT_W-1:0]    records_done;

   result_type            step_results[$];
   result_type            pending_words[$];
   stim_row_type          directed_rows[$];

   int                    tx_idle_pct = 0;
   int                    rx_idle_pct = 0;
   int                    errors      = 0;
   int                    items_sent  = 0;

   dictionary_index_record_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type mk_result(kind_type k, logic [7:0] wc, logic [7:0] lc,
                                            logic [63:0] off, logic [31:0] sz,
                                            logic [31:0] seen, logic none, logic fin);
      result_type r;
      r.kind         = k;
      r.word_char    = wc;
      r.lower_char   = lc;
      r.entry_offset = off;
      r.entry_size   = sz;
      r.records_seen = seen;
      r.no_records   = none;
      r.run_end      = fin;
      return r;
   endfunction

   function automatic void book_result(result_type r);
      step_results.insert(step_results.size(), r);
   endfunction

   function automatic void forget_record();
      reading_meta   = 1'b0;
      meta_taken     = '0;
      record_started = 1'b0;
      offset_built   = '0;
      size_built     = '0;
   endfunction

   // next state and results of the parser for one accepted byte
   function automatic void parse_byte(logic [7:0] b, bit fin);
      int unsigned off_len;
      bit          completed;
      logic [7:0]  lc;
      off_len   = wide_model ? WIDE_OFFSET_BYTES : NARROW_OFFSET_BYTES;
      completed = 1'b0;
      step_results.delete();
      if (!reading_meta) begin
         record_started = 1'b1;
         if (b == 8'h00) begin
            reading_meta = 1'b1;
            meta_taken   = '0;
            offset_built = '0;
            size_built   = '0;
         end else if (!fin) begin
            lc = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_DELTA : b;
            book_result(mk_result(KIND_WORD, b, lc, '0, '0, '0, 1'b0, 1'b0));
         end
      end else begin
         if (meta_taken < off_len)
            offset_built = {offset_built[OFFSET_W-9:0], b};
         else
            size_built = {size_built[SIZE_W-9:0], b};
         meta_taken = meta_taken + 1'b1;
         if (meta_taken >= off_len + SIZE_BYTES) begin
            book_result(mk_result(KIND_RECORD, '0, '0, offset_built, size_built,
                                  '0, 1'b0, 1'b0));
            if (records_done != '1)
               records_done = records_done + 1'b1;
            forget_record();
            completed = 1'b1;
         end
      end
      if (fin) begin
         if (!completed && record_started)
            book_result(mk_result(KIND_DROPPED, '0, '0, '0, '0, '0, 1'b0, 1'b0));
         book_result(mk_result(KIND_SUMMARY, '0, '0, '0, '0, records_done,
                               records_done == '0, 1'b0));
         forget_record();
         records_done = '0;
      end
      if (step_results.size() > 0)
         step_results[step_results.size()-1].run_end = 1'b1;
   endfunction

   function automatic void add_row(logic [7:0] d, bit l, width_action_type a = CFG_KEEP,
                                   int n = 0, result_type t0 = NO_RESULT,
                                   result_type t1 = NO_RESULT);
      stim_row_type row;
      row.data    = d;
      row.last    = l;
      row.action  = a;
      row.n_typed = n;
      row.typed0  = t0;
      row.typed1  = t1;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // offer one byte, wait for its handshake, then book what it should produce
   task automatic send_byte(logic [7:0] b, bit fin, int n_typed = 0,
                            result_type t0 = NO_RESULT, result_type t1 = NO_RESULT);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      parse_byte(b, fin);
      if (n_typed > 0) begin
         pending_words.insert(pending_words.size(), t0);
         if (n_typed > 1)
            pending_words.insert(pending_words.size(), t1);
      end else begin
         foreach (step_results[i])
            pending_words.insert(pending_words.size(), step_results[i]);
      end
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_width(bit w);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      wide_model  = w;
   endtask

   function automatic logic [7:0] random_word_byte();
      case ($urandom_range(2))
         0:       return 8'($urandom_range(8'h41, 8'h5A));
         1:       return 8'($urandom_range(8'h61, 8'h7A));
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // one buffer: mostly whole records, some cut short, some plain noise
   task automatic send_random_buffer();
      logic [7:0] bytes[$];
      int         n_rec;
      int         wlen;
      int         fill;
      int         cut;
      int         flip_at;
      int unsigned off_len;
      off_len = wide_model ? WIDE_OFFSET_BYTES : NARROW_OFFSET_BYTES;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 12))
            bytes.insert(bytes.size(),
                         ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)));
      end else begin
         n_rec = $urandom_range(1, 4);
         repeat (n_rec) begin
            wlen = $urandom_range(0, 6);
            repeat (wlen) bytes.insert(bytes.size(), random_word_byte());
            bytes.insert(bytes.size(), 8'h00);
            fill = $urandom_range(3);
            repeat (off_len + SIZE_BYTES)
               bytes.insert(bytes.size(), fill == 0 ? 8'h00 :
                                          fill == 1 ? 8'hFF : 8'($urandom_range(255)));
         end
         if ($urandom_range(99) < 35) begin
            cut = $urandom_range(1, bytes.size());
            while (bytes.size() > cut)
               void'(bytes.pop_back());
         end
      end
      flip_at = ($urandom_range(99) < 10) ? $urandom_range(bytes.size() - 1) : -1;
      foreach (bytes[i]) begin
         if (i == flip_at)
            write_width(!wide_model);
         send_byte(bytes[i], i == bytes.size() - 1);
      end
   endtask

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("result word with nothing expected: kind %0d", rsp_tuser);
            errors++;
         end else begin
            want = pending_words.pop_front();
            check_field("result_kind",  64'(want.kind),         64'(rsp_tuser));
            check_field("word_char",    64'(want.word_char),    64'(rsp_tdata[7:0]));
            check_field("lower_char",   64'(want.lower_char),   64'(rsp_tdata[15:8]));
            check_field("entry_offset", want.entry_offset,      rsp_tdata[79:16]);
            check_field("entry_size",   64'(want.entry_size),   64'(rsp_tdata[111:80]));
            check_field("records_seen", 64'(want.records_seen), 64'(rsp_tdata[143:112]));
            check_field("no_records",   64'(want.no_records),   64'(rsp_tdata[144]));
            check_field("run_end",      64'(want.run_end),      64'(rsp_tlast));
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

   initial begin
      wide_model   = 1'b0;
      records_done = '0;
      forget_record();

      // terminator as the final byte right after reset: dropped, then empty summary
      add_row(8'h00, 1'b1, CFG_KEEP, 2,
              mk_result(KIND_DROPPED, '0, '0, '0, '0, '0, 1'b0, 1'b0),
              mk_result(KIND_SUMMARY, '0, '0, '0, '0, '0, 1'b1, 1'b1));
      add_row(8'h41, 1'b0, CFG_KEEP, 1,
              mk_result(KIND_WORD, 8'h41, 8'h61, '0, '0, '0, 1'b0, 1'b1));
      add_row(8'h5A, 1'b0, CFG_KEEP, 1,
              mk_result(KIND_WORD, 8'h5A, 8'h7A, '0, '0, '0, 1'b0, 1'b1));
      add_row(8'h40, 1'b0);
      add_row(8'h5B, 1'b0);
      add_row(8'hFF, 1'b0, CFG_KEEP, 1,
              mk_result(KIND_WORD, 8'hFF, 8'hFF, '0, '0, '0, 1'b0, 1'b1));
      add_row(8'h00, 1'b0);
      repeat (7) add_row(8'hFF, 1'b0);
      // record completed by the final byte
      add_row(8'hFF, 1'b1, CFG_KEEP, 2,
              mk_result(KIND_RECORD, '0, '0, 64'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0, 1'b0),
              mk_result(KIND_SUMMARY, '0, '0, '0, '0, 32'd1, 1'b0, 1'b1));
      // empty word, then the offset width drops from 8 to 4 in the middle of the record
      add_row(8'h00, 1'b0, CFG_WIDE);
      add_row(8'h01, 1'b0);
      add_row(8'h02, 1'b0);
      add_row(8'h03, 1'b0);
      add_row(8'h04, 1'b0);
      add_row(8'h05, 1'b0, CFG_NARROW);
      add_row(8'h06, 1'b0);
      add_row(8'h07, 1'b0);
      add_row(8'h08, 1'b0);
      // word byte on the final byte gives no word result
      add_row(8'h78, 1'b1);
      // offset cut short by the final byte
      add_row(8'h00, 1'b0);
      add_row(8'h12, 1'b1, CFG_KEEP, 2,
              mk_result(KIND_DROPPED, '0, '0, '0, '0, '0, 1'b0, 1'b0),
              mk_result(KIND_SUMMARY, '0, '0, '0, '0, '0, 1'b1, 1'b1));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      tx_idle_pct = 29;
      rx_idle_pct = 65;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].action == CFG_WIDE)
            write_width(1'b1);
         else if (directed_rows[i].action == CFG_NARROW)
            write_width(1'b0);
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].n_typed,
                   directed_rows[i].typed0, directed_rows[i].typed1);
      end

      items_sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 65 : 0;
         rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 29 : 0;
         // sender holds off until the block has emptied
         wait_idle();
         while (items_sent < RANDOM_ITEMS * (phase + 1) / 3) begin
            if ($urandom_range(99) < 30)
               write_width(1'($urandom_range(1)));
            send_random_buffer();
         end
      end

      wait_idle();
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### filelist.f
hdl/dirp_pkg.sv
hdl/dictionary_index_record_parser.sv
verif/tb_dictionary_index_record_parser.sv
